>>> src/hbsi_pkg.sv
`timescale 1ns / 1ps

package hbsi_pkg;

   // Fixed widths of the beat fields.
   localparam int KIND_W       = 2;
   localparam int SIZE_FIELD_W = 8;
   localparam int ADDR_W       = 11;

   // Operation codes carried in the request tuser.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

   // Word-occupancy words are always 64 bits wide.
   localparam int WOC_BITS  = 64;
   localparam int WOC_IDX_W = 6;

   // Operand width of the shared multiplier; it covers every parameter in range.
   localparam int MUL_W = 16;

   // Default sizing of the index.
   localparam int DEF_NUM_SIZES      = 256;
   localparam int DEF_NUM_ADDRS      = 2048;
   localparam int DEF_LEAF_WORD_BITS = 32;
   localparam int DEF_TOP_WORD_BITS  = 64;

   // Position of the lowest set bit of a word; zero for an empty word.
   function automatic logic [WOC_IDX_W-1:0] lowest_bit(input logic [WOC_BITS-1:0] v);
      logic [WOC_IDX_W-1:0] pos;
      pos = '0;
      for (int i = WOC_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = WOC_IDX_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

>>> src/hbsi_mul.sv
`timescale 1ns / 1ps

// Shared multiplier: the product of the operands presented in one cycle is
// available from the register in the next.
module hbsi_mul (
   input  logic                           clock,
   input  logic [hbsi_pkg::MUL_W-1:0]     mul_a,
   input  logic [hbsi_pkg::MUL_W-1:0]     mul_b,
   output logic [2*hbsi_pkg::MUL_W-1:0]   prod_ff
);

   logic [2*hbsi_pkg::MUL_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> src/hierarchical_bitmap_size_index.sv
`timescale 1ns / 1ps

// Best-fit size index over a three-level bitmap: one bit per size class held in
// flip-flops, per size class one bit per leaf word in a word-occupancy memory, and
// the leaf words themselves in a second memory. A request beat carries the
// operation in tuser (insert, remove, find); only a find returns a response beat.
// One operation is in work at a time and the request side is not ready meanwhile.
// An insert also writes every word-occupancy word of the size class when that
// class was empty; a remove also reads them all back when a leaf word empties; a
// find scans the size-occupancy words and then the word-occupancy words of the
// class it hits, and waits while a previous response beat is still held in the
// output register. The operations are sequenced around the single shared
// multiplier, which forms every quotient estimate and memory address in turn,
// and around the one read port of each memory. There is no clearing pass after
// reset: only the size-class bits, the sequencer state and the response valid
// flag are reset, and a memory word is trusted only when the level above marks
// it as written, so the index is usable as soon as reset is released.
module hierarchical_bitmap_size_index #(
   parameter int NUM_SIZES      = hbsi_pkg::DEF_NUM_SIZES,
   parameter int NUM_ADDRS      = hbsi_pkg::DEF_NUM_ADDRS,
   parameter int LEAF_WORD_BITS = hbsi_pkg::DEF_LEAF_WORD_BITS,
   parameter int TOP_WORD_BITS  = hbsi_pkg::DEF_TOP_WORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // size class [7:0], address slot [18:8], zero fill
   input  logic [1:0]  req_tuser,   // kind [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // best_size [7:0], best_addr [18:8], zero fill
   output logic        rsp_tuser    // found [0]
);

   // Derived sizing.
   localparam int LEAF_WORDS = (NUM_ADDRS + LEAF_WORD_BITS - 1) / LEAF_WORD_BITS;
   localparam int WOCC       = (LEAF_WORDS + hbsi_pkg::WOC_BITS - 1) / hbsi_pkg::WOC_BITS;
   localparam int TOP_WORDS  = (NUM_SIZES + TOP_WORD_BITS - 1) / TOP_WORD_BITS;
   localparam int SOCC_BITS  = TOP_WORDS * TOP_WORD_BITS;
   localparam int WOC_DEPTH  = NUM_SIZES * WOCC;
   localparam int LEAF_DEPTH = NUM_SIZES * LEAF_WORDS;

   localparam int SIZE_W = (NUM_SIZES > 1) ? $clog2(NUM_SIZES) : 1;
   localparam int SB_W   = (SOCC_BITS > 1) ? $clog2(SOCC_BITS) : 1;
   localparam int LW_W   = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;
   localparam int LB_W   = $clog2(LEAF_WORD_BITS);
   localparam int TW_W   = (TOP_WORDS > 1) ? $clog2(TOP_WORDS) : 1;
   localparam int TB_W   = $clog2(TOP_WORD_BITS);
   localparam int JW     = (WOCC > 1) ? $clog2(WOCC) : 1;
   localparam int WA_W   = (WOC_DEPTH > 1) ? $clog2(WOC_DEPTH) : 1;
   localparam int LA_W   = (LEAF_DEPTH > 1) ? $clog2(LEAF_DEPTH) : 1;
   localparam int WEXT_W = LW_W + hbsi_pkg::WOC_IDX_W;
   localparam int AW     = hbsi_pkg::ADDR_W;
   localparam int MW     = hbsi_pkg::MUL_W;

   // Reciprocals for dividing values below 2**ADDR_W by the word widths.
   localparam int RECIP_LEAF = (2 ** hbsi_pkg::ADDR_W) / LEAF_WORD_BITS;
   localparam int RECIP_TOP  = (2 ** hbsi_pkg::ADDR_W) / TOP_WORD_BITS;

   // Sequencer states.
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_QEST  = 5'd1;
   localparam logic [4:0] ST_QFIX  = 5'd2;
   localparam logic [4:0] ST_WADR  = 5'd3;
   localparam logic [4:0] ST_LADR  = 5'd4;
   localparam logic [4:0] ST_LEAF  = 5'd5;
   localparam logic [4:0] ST_WFILL = 5'd6;
   localparam logic [4:0] ST_RRD   = 5'd7;
   localparam logic [4:0] ST_RCK   = 5'd8;
   localparam logic [4:0] ST_FTOP  = 5'd9;
   localparam logic [4:0] ST_FSIZE = 5'd10;
   localparam logic [4:0] ST_FWB   = 5'd11;
   localparam logic [4:0] ST_FWC   = 5'd12;
   localparam logic [4:0] ST_FLA   = 5'd13;
   localparam logic [4:0] ST_FLD   = 5'd14;
   localparam logic [4:0] ST_EMIT  = 5'd15;

   // Request fields.
   logic [hbsi_pkg::KIND_W-1:0]       req_kind;
   logic [hbsi_pkg::SIZE_FIELD_W-1:0] req_size;
   logic [AW-1:0]                     req_addr;

   assign req_kind = req_tuser;
   assign req_size = req_tdata[7:0];
   assign req_addr = req_tdata[18:8];

   // Control and operand registers.
   logic [4:0]                  state_ff, state_in;
   logic [hbsi_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [SIZE_W-1:0]           s_ff, s_in;
   logic [AW-1:0]               x_ff, x_in;
   logic [AW-1:0]               q_ff, q_in;
   logic [LW_W-1:0]             w_ff, w_in;
   logic [LB_W-1:0]             b_ff, b_in;
   logic [TW_W-1:0]             tw_ff, tw_in;
   logic [TOP_WORD_BITS-1:0]    mask_ff, mask_in;
   logic [TB_W-1:0]             lb_ff, lb_in;
   logic [JW-1:0]               j_ff, j_in;
   logic [WA_W-1:0]             woc_base_ff, woc_base_in;
   logic [LA_W-1:0]             leaf_addr_ff, leaf_addr_in;
   logic [LW_W-1:0]             lw_ff, lw_in;
   logic                        wbit_ff, wbit_in;
   logic                        any_ff, any_in;
   logic [SOCC_BITS-1:0]        socc_ff, socc_in;

   // Result held until the output register is free, and the output register.
   logic                              res_found_ff, res_found_in;
   logic [hbsi_pkg::SIZE_FIELD_W-1:0] res_size_ff, res_size_in;
   logic [AW-1:0]                     res_addr_ff, res_addr_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [hbsi_pkg::SIZE_FIELD_W-1:0] rsp_size_ff, rsp_size_in;
   logic [AW-1:0]                     rsp_addr_ff, rsp_addr_in;

   // Memory ports.
   logic                          woc_re, woc_we;
   logic [WA_W-1:0]               woc_raddr, woc_waddr;
   logic [hbsi_pkg::WOC_BITS-1:0] woc_wdata, woc_q_ff;
   logic                          leaf_re, leaf_we;
   logic [LA_W-1:0]               leaf_raddr, leaf_waddr;
   logic [LEAF_WORD_BITS-1:0]     leaf_wdata, leaf_q_ff;

   logic [hbsi_pkg::WOC_BITS-1:0] woc_mem [WOC_DEPTH];
   logic [LEAF_WORD_BITS-1:0]     leaf_mem [LEAF_DEPTH];

   // Shared multiplier.
   logic [MW-1:0]   mul_a, mul_b;
   logic [2*MW-1:0] prod_ff;

   hbsi_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // Views of the size-class bits and of the current word indexes.
   logic [TOP_WORDS-1:0][TOP_WORD_BITS-1:0] socc_words;
   logic                                    sbit;
   logic [WEXT_W-1:0]                       w_ext;
   logic [hbsi_pkg::WOC_IDX_W-1:0]          w_lo;
   logic [JW-1:0]                           w_hi;

   assign socc_words = socc_ff;
   assign sbit       = socc_ff[SB_W'(s_ff)];
   assign w_ext      = WEXT_W'(w_ff);
   assign w_lo       = w_ext[hbsi_pkg::WOC_IDX_W-1:0];
   assign w_hi       = JW'(w_ext >> hbsi_pkg::WOC_IDX_W);

   // Handshake outputs.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {5'b0, rsp_addr_ff, rsp_size_ff};

   // Sequencer and datapath.
   always_comb begin
      logic [AW:0]                   r12;
      logic [AW:0]                   d12;
      logic                          fix;
      logic [AW-1:0]                 qf;
      logic [AW:0]                   rf;
      logic [LEAF_WORD_BITS-1:0]     leaf_word, leaf_bit, leaf_new;
      logic [hbsi_pkg::WOC_BITS-1:0] woc_word, woc_bit;
      logic [TOP_WORD_BITS-1:0]      top_bits;
      logic                          any_now;
      logic [WEXT_W-1:0]             lw_full;
      logic [SB_W-1:0]               s_sum;

      state_in     = state_ff;
      kind_in      = kind_ff;
      s_in         = s_ff;
      x_in         = x_ff;
      q_in         = q_ff;
      w_in         = w_ff;
      b_in         = b_ff;
      tw_in        = tw_ff;
      mask_in      = mask_ff;
      lb_in        = lb_ff;
      j_in         = j_ff;
      woc_base_in  = woc_base_ff;
      leaf_addr_in = leaf_addr_ff;
      lw_in        = lw_ff;
      wbit_in      = wbit_ff;
      any_in       = any_ff;
      socc_in      = socc_ff;
      res_found_in = res_found_ff;
      res_size_in  = res_size_ff;
      res_addr_in  = res_addr_ff;

      mul_a      = '0;
      mul_b      = '0;
      woc_re     = 1'b0;
      woc_raddr  = woc_base_ff;
      woc_we     = 1'b0;
      woc_waddr  = woc_base_ff + WA_W'(w_hi);
      woc_wdata  = '0;
      leaf_re    = 1'b0;
      leaf_raddr = leaf_addr_ff;
      leaf_we    = 1'b0;
      leaf_waddr = leaf_addr_ff;
      leaf_wdata = '0;

      // Quotient correction, shared by both divisors.
      d12 = (kind_ff == hbsi_pkg::KIND_FIND) ? (AW + 1)'(TOP_WORD_BITS)
                                              : (AW + 1)'(LEAF_WORD_BITS);
      r12 = {1'b0, x_ff} - prod_ff[AW:0];
      fix = (r12 >= d12);
      qf  = q_ff + AW'(fix);
      rf  = fix ? (r12 - d12) : r12;

      // Words as read, with unwritten words standing for empty ones.
      leaf_word = wbit_ff ? leaf_q_ff : '0;
      leaf_bit  = {{(LEAF_WORD_BITS - 1){1'b0}}, 1'b1} << b_ff;
      leaf_new  = '0;
      woc_word  = sbit ? woc_q_ff : '0;
      woc_bit   = {{(hbsi_pkg::WOC_BITS - 1){1'b0}}, 1'b1} << w_lo;
      top_bits  = socc_words[tw_ff] & mask_ff;
      any_now   = any_ff | (woc_q_ff != '0);
      lw_full   = (WEXT_W'(j_ff) << hbsi_pkg::WOC_IDX_W)
                | WEXT_W'(hbsi_pkg::lowest_bit(woc_q_ff));
      s_sum     = SB_W'(prod_ff) + SB_W'(lb_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_kind;
               s_in    = SIZE_W'(req_size);
               if (req_kind == hbsi_pkg::KIND_FIND) begin
                  x_in  = AW'(req_size);
                  mul_a = MW'(req_size);
                  mul_b = MW'(RECIP_TOP);
                  if (32'(req_size) < NUM_SIZES) begin
                     state_in = ST_QEST;
                  end else begin
                     res_found_in = 1'b0;
                     res_size_in  = '0;
                     res_addr_in  = '0;
                     state_in     = ST_EMIT;
                  end
               end else if (req_kind == hbsi_pkg::KIND_INSERT ||
                            req_kind == hbsi_pkg::KIND_REMOVE) begin
                  x_in  = req_addr;
                  mul_a = MW'(req_addr);
                  mul_b = MW'(RECIP_LEAF);
                  if (32'(req_size) < NUM_SIZES && 32'(req_addr) < NUM_ADDRS) begin
                     state_in = ST_QEST;
                  end
               end
            end
         end

         // Quotient estimate, then multiply back for the remainder.
         ST_QEST: begin
            q_in  = prod_ff[AW +: AW];
            mul_a = MW'(prod_ff[AW +: AW]);
            mul_b = MW'(d12);
            state_in = ST_QFIX;
         end

         ST_QFIX: begin
            if (kind_ff == hbsi_pkg::KIND_FIND) begin
               tw_in    = TW_W'(qf);
               mask_in  = {TOP_WORD_BITS{1'b1}} << rf[TB_W-1:0];
               state_in = ST_FTOP;
            end else begin
               w_in     = LW_W'(qf);
               b_in     = rf[LB_W-1:0];
               mul_a    = MW'(s_ff);
               mul_b    = MW'(WOCC);
               state_in = ST_WADR;
            end
         end

         // Word-occupancy base of the size class; read the word that covers w.
         ST_WADR: begin
            woc_base_in = WA_W'(prod_ff);
            woc_re      = 1'b1;
            woc_raddr   = WA_W'(prod_ff) + WA_W'(w_hi);
            mul_a       = MW'(s_ff);
            mul_b       = MW'(LEAF_WORDS);
            state_in    = ST_LADR;
         end

         // Leaf address; the leaf word is valid only if its occupancy bit is set.
         ST_LADR: begin
            leaf_addr_in = LA_W'(prod_ff) + LA_W'(w_ff);
            leaf_re      = 1'b1;
            leaf_raddr   = LA_W'(prod_ff) + LA_W'(w_ff);
            wbit_in      = sbit & woc_q_ff[w_lo];
            state_in     = ST_LEAF;
         end

         ST_LEAF: begin
            if (kind_ff == hbsi_pkg::KIND_INSERT) begin
               leaf_we    = 1'b1;
               leaf_wdata = leaf_word | leaf_bit;
               if (sbit) begin
                  woc_we    = 1'b1;
                  woc_wdata = woc_word | woc_bit;
                  state_in  = ST_IDLE;
               end else begin
                  // A newly occupied size class: write all its occupancy words.
                  socc_in[SB_W'(s_ff)] = 1'b1;
                  j_in     = '0;
                  state_in = ST_WFILL;
               end
            end else begin
               leaf_new = leaf_word & ~leaf_bit;
               if (!wbit_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  leaf_we    = 1'b1;
                  leaf_wdata = leaf_new;
                  if (leaf_new != '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     woc_we    = 1'b1;
                     woc_wdata = woc_word & ~woc_bit;
                     j_in      = '0;
                     any_in    = 1'b0;
                     state_in  = ST_RRD;
                  end
               end
            end
         end

         ST_WFILL: begin
            woc_we    = 1'b1;
            woc_waddr = woc_base_ff + WA_W'(j_ff);
            woc_wdata = (j_ff == w_hi) ? woc_bit : '0;
            j_in      = j_ff + JW'(1);
            if (j_ff == JW'(WOCC - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // Check whether any occupancy word of the size class is still set.
         ST_RRD: begin
            woc_re    = 1'b1;
            woc_raddr = woc_base_ff + WA_W'(j_ff);
            state_in  = ST_RCK;
         end

         ST_RCK: begin
            if (j_ff == JW'(WOCC - 1)) begin
               if (!any_now) begin
                  socc_in[SB_W'(s_ff)] = 1'b0;
               end
               state_in = ST_IDLE;
            end else begin
               any_in   = any_now;
               j_in     = j_ff + JW'(1);
               state_in = ST_RRD;
            end
         end

         // Scan the size-class words upwards from the request.
         ST_FTOP: begin
            if (top_bits != '0) begin
               lb_in    = TB_W'(hbsi_pkg::lowest_bit(hbsi_pkg::WOC_BITS'(top_bits)));
               mul_a    = MW'(tw_ff);
               mul_b    = MW'(TOP_WORD_BITS);
               state_in = ST_FSIZE;
            end else if (tw_ff == TW_W'(TOP_WORDS - 1)) begin
               res_found_in = 1'b0;
               res_size_in  = '0;
               res_addr_in  = '0;
               state_in     = ST_EMIT;
            end else begin
               tw_in   = tw_ff + TW_W'(1);
               mask_in = '1;
            end
         end

         ST_FSIZE: begin
            s_in     = SIZE_W'(s_sum);
            mul_a    = MW'(s_sum);
            mul_b    = MW'(WOCC);
            state_in = ST_FWB;
         end

         ST_FWB: begin
            woc_base_in = WA_W'(prod_ff);
            woc_re      = 1'b1;
            woc_raddr   = WA_W'(prod_ff);
            j_in        = '0;
            state_in    = ST_FWC;
         end

         // One occupancy word per cycle: check the word read, fetch the next.
         ST_FWC: begin
            if (woc_q_ff != '0) begin
               lw_in    = LW_W'(lw_full);
               mul_a    = MW'(s_ff);
               mul_b    = MW'(LEAF_WORDS);
               state_in = ST_FLA;
            end else if (j_ff == JW'(WOCC - 1)) begin
               res_found_in = 1'b0;
               res_size_in  = '0;
               res_addr_in  = '0;
               state_in     = ST_EMIT;
            end else begin
               j_in      = j_ff + JW'(1);
               woc_re    = 1'b1;
               woc_raddr = woc_base_ff + WA_W'(j_ff + JW'(1));
            end
         end

         ST_FLA: begin
            leaf_re    = 1'b1;
            leaf_raddr = LA_W'(prod_ff) + LA_W'(lw_ff);
            mul_a      = MW'(lw_ff);
            mul_b      = MW'(LEAF_WORD_BITS);
            state_in   = ST_FLD;
         end

         ST_FLD: begin
            res_found_in = 1'b1;
            res_size_in  = hbsi_pkg::SIZE_FIELD_W'(s_ff);
            res_addr_in  = AW'(prod_ff)
                         + AW'(hbsi_pkg::lowest_bit(hbsi_pkg::WOC_BITS'(leaf_q_ff)));
            state_in     = ST_EMIT;
         end

         // Wait for the output register to be free.
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load a result when free, drop a beat once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_EMIT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = res_found_ff;
         rsp_size_in  = res_size_ff;
         rsp_addr_in  = res_addr_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         socc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         socc_ff      <= socc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      s_ff         <= s_in;
      x_ff         <= x_in;
      q_ff         <= q_in;
      w_ff         <= w_in;
      b_ff         <= b_in;
      tw_ff        <= tw_in;
      mask_ff      <= mask_in;
      lb_ff        <= lb_in;
      j_ff         <= j_in;
      woc_base_ff  <= woc_base_in;
      leaf_addr_ff <= leaf_addr_in;
      lw_ff        <= lw_in;
      wbit_ff      <= wbit_in;
      any_ff       <= any_in;
      res_found_ff <= res_found_in;
      res_size_ff  <= res_size_in;
      res_addr_ff  <= res_addr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   // Word-occupancy memory.
   always_ff @(posedge clock) begin
      if (woc_we) begin
         woc_mem[woc_waddr] <= woc_wdata;
      end
      if (woc_re) begin
         woc_q_ff <= woc_mem[woc_raddr];
      end
   end

   // Leaf memory.
   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[leaf_waddr] <= leaf_wdata;
      end
      if (leaf_re) begin
         leaf_q_ff <= leaf_mem[leaf_raddr];
      end
   end

endmodule

>>> tb/hierarchical_bitmap_size_index_tb.sv
`timescale 1ns / 1ps

module hierarchical_bitmap_size_index_tb;

   localparam int NUM_SIZES      = hbsi_pkg::DEF_NUM_SIZES;
   localparam int NUM_ADDRS      = hbsi_pkg::DEF_NUM_ADDRS;
   localparam int LEAF_WORD_BITS = hbsi_pkg::DEF_LEAF_WORD_BITS;
   localparam int TOP_WORD_BITS  = hbsi_pkg::DEF_TOP_WORD_BITS;
   localparam int LEAF_WORDS     = (NUM_ADDRS + LEAF_WORD_BITS - 1) / LEAF_WORD_BITS;
   localparam int KW             = hbsi_pkg::KIND_W;
   localparam int SW             = hbsi_pkg::SIZE_FIELD_W;
   localparam int AW             = hbsi_pkg::ADDR_W;

   // Kind code that the block must ignore.
   localparam logic [KW-1:0] KIND_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic          found;
      logic [SW-1:0] best_size;
      logic [AW-1:0] best_addr;
   } best_fit_type;

   typedef struct packed {
      logic [SW-1:0] size_class;
      logic [AW-1:0] slot;
   } slot_ref_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // size class [7:0], address slot [18:8], zero fill
   logic [1:0]  req_tuser = '0;   // kind [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // best_size [7:0], best_addr [18:8], zero fill
   logic        rsp_tuser;        // found [0]

   hierarchical_bitmap_size_index #(
      .NUM_SIZES      (NUM_SIZES),
      .NUM_ADDRS      (NUM_ADDRS),
      .LEAF_WORD_BITS (LEAF_WORD_BITS),
      .TOP_WORD_BITS  (TOP_WORD_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-slot index kept by the testbench: class bits, leaf-word bits and leaf words.
   logic [NUM_SIZES-1:0]      class_map;
   logic [LEAF_WORDS-1:0]     word_map   [NUM_SIZES];
   logic [LEAF_WORD_BITS-1:0] slot_words [NUM_SIZES][LEAF_WORDS];

   best_fit_type expected_finds[$];
   slot_ref_type live_slots[$];

   int errors = 0;
   bit quiet = 1'b0;
   bit hold_start = 1'b0;
   int hold_left = 0;
   int stall_left = 0;
   int win_base = 0;
   int win_span = 8;
   int cluster_word = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Position of the lowest set bit; zero for an empty word.
   function automatic int lowest_set(input logic [63:0] v);
      int pos;
      pos = 0;
      for (int i = 63; i >= 0; i--) begin
         if (v[i]) pos = i;
      end
      return pos;
   endfunction

   function automatic void index_insert(input int s, input int a);
      int w;
      w = a / LEAF_WORD_BITS;
      slot_words[s][w][a % LEAF_WORD_BITS] = 1'b1;
      word_map[s][w] = 1'b1;
      class_map[s] = 1'b1;
   endfunction

   // Upper bits are cleared only once everything beneath them is empty.
   function automatic void index_remove(input int s, input int a);
      int w;
      w = a / LEAF_WORD_BITS;
      slot_words[s][w][a % LEAF_WORD_BITS] = 1'b0;
      if (slot_words[s][w] == '0) begin
         word_map[s][w] = 1'b0;
         if (word_map[s] == '0) class_map[s] = 1'b0;
      end
   endfunction

   // Smallest occupied class at or above the request, and its lowest slot.
   function automatic best_fit_type predict_best_fit(input logic [SW-1:0] req);
      best_fit_type r;
      int hit;
      int w;
      r = '0;
      hit = -1;
      for (int s = int'(req); s < NUM_SIZES; s++) begin
         if (hit < 0 && class_map[s]) hit = s;
      end
      if (hit >= 0) begin
         w = lowest_set(64'(word_map[hit]));
         r.found = 1'b1;
         r.best_size = SW'(hit);
         r.best_addr = AW'(w * LEAF_WORD_BITS + lowest_set(64'(slot_words[hit][w])));
      end
      return r;
   endfunction

   // Idle lengths: mostly short, sometimes medium, rarely long.
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SW-1:0] pick_size();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         v = win_base + $urandom_range(0, win_span);
         if (v > NUM_SIZES - 1) v = NUM_SIZES - 1;
      end else if (r < 90) begin
         v = $urandom_range(0, NUM_SIZES - 1);
      end else begin
         v = ($urandom_range(0, 1) != 0) ? NUM_SIZES - 1 : 0;
      end
      return SW'(v);
   endfunction

   function automatic logic [AW-1:0] pick_slot();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         v = $urandom_range(0, NUM_ADDRS - 1);
      end else if (r < 80) begin
         v = cluster_word * LEAF_WORD_BITS + $urandom_range(0, LEAF_WORD_BITS - 1);
      end else begin
         case ($urandom_range(0, 3))
            0: v = 0;
            1: v = LEAF_WORD_BITS - 1;
            2: v = NUM_ADDRS - LEAF_WORD_BITS;
            default: v = NUM_ADDRS - 1;
         endcase
      end
      return AW'(v);
   endfunction

   // Takes a random slot believed present out of the list of inserted slots.
   function automatic slot_ref_type take_live_slot();
      slot_ref_type entry;
      int idx;
      idx = $urandom_range(0, live_slots.size() - 1);
      entry = live_slots[idx];
      live_slots.delete(idx);
      return entry;
   endfunction

   // Offers one request beat, waits for it to be taken and updates the index.
   task automatic send_beat(input logic [KW-1:0] kind,
                            input logic [SW-1:0] size_class,
                            input logic [AW-1:0] slot);
      int gap;
      gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_idle();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, slot, size_class};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (kind)
         hbsi_pkg::KIND_INSERT: begin
            if (int'(size_class) < NUM_SIZES && int'(slot) < NUM_ADDRS) begin
               index_insert(int'(size_class), int'(slot));
               live_slots.push_back({size_class, slot});
            end
         end
         hbsi_pkg::KIND_REMOVE: begin
            if (int'(size_class) < NUM_SIZES && int'(slot) < NUM_ADDRS)
               index_remove(int'(size_class), int'(slot));
         end
         hbsi_pkg::KIND_FIND: expected_finds.push_back(predict_best_fit(size_class));
         default: ;
      endcase
   endtask

   task automatic end_stream();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic new_window();
      win_base = $urandom_range(0, NUM_SIZES - 1);
      win_span = $urandom_range(0, 15);
      cluster_word = $urandom_range(0, LEAF_WORDS - 1);
   endtask

   // One random operation; removes mostly target slots that are present.
   task automatic send_random_item();
      int r;
      logic [KW-1:0] k;
      logic [SW-1:0] s;
      logic [AW-1:0] a;
      slot_ref_type entry;
      r = $urandom_range(0, 99);
      s = pick_size();
      a = pick_slot();
      if (r < 38) begin
         k = hbsi_pkg::KIND_INSERT;
      end else if (r < 63) begin
         k = hbsi_pkg::KIND_REMOVE;
         if (live_slots.size() > 0 && $urandom_range(0, 4) != 0) begin
            entry = take_live_slot();
            s = entry.size_class;
            a = entry.slot;
         end
      end else if (r < 95) begin
         k = hbsi_pkg::KIND_FIND;
      end else begin
         k = KIND_UNUSED;
      end
      send_beat(k, s, a);
   endtask

   task automatic test_empty_index();
      send_beat(hbsi_pkg::KIND_FIND, 8'd0, 11'd0);
      send_beat(hbsi_pkg::KIND_FIND, 8'd255, 11'h7FF);
      end_stream();
   endtask

   // Extreme classes and slots, repeated inserts, absent removes and the unused kind.
   task automatic test_extreme_slots();
      send_beat(hbsi_pkg::KIND_INSERT, 8'd0, 11'd0);
      send_beat(hbsi_pkg::KIND_INSERT, 8'd255, 11'd2047);
      send_beat(hbsi_pkg::KIND_FIND, 8'd0, 11'd0);
      send_beat(hbsi_pkg::KIND_FIND, 8'd1, 11'h7FF);
      send_beat(hbsi_pkg::KIND_FIND, 8'd255, 11'd0);
      send_beat(hbsi_pkg::KIND_INSERT, 8'd0, 11'd0);
      send_beat(hbsi_pkg::KIND_REMOVE, 8'd0, 11'd0);
      send_beat(hbsi_pkg::KIND_FIND, 8'd0, 11'd0);
      send_beat(hbsi_pkg::KIND_REMOVE, 8'd0, 11'd0);
      send_beat(hbsi_pkg::KIND_REMOVE, 8'd255, 11'd2047);
      send_beat(hbsi_pkg::KIND_FIND, 8'd0, 11'd0);
      send_beat(KIND_UNUSED, 8'hFF, 11'h7FF);
      send_beat(hbsi_pkg::KIND_FIND, 8'd255, 11'd0);
      end_stream();
   endtask

   // A leaf word that keeps one bit after a remove, then empties.
   task automatic test_shared_leaf_word();
      send_beat(hbsi_pkg::KIND_INSERT, 8'd7, 11'd33);
      send_beat(hbsi_pkg::KIND_INSERT, 8'd7, 11'd63);
      send_beat(hbsi_pkg::KIND_INSERT, 8'd9, 11'd0);
      send_beat(hbsi_pkg::KIND_REMOVE, 8'd7, 11'd33);
      send_beat(hbsi_pkg::KIND_FIND, 8'd7, 11'd0);
      send_beat(hbsi_pkg::KIND_FIND, 8'd8, 11'd0);
      send_beat(hbsi_pkg::KIND_REMOVE, 8'd7, 11'd63);
      send_beat(hbsi_pkg::KIND_FIND, 8'd0, 11'd0);
      send_beat(hbsi_pkg::KIND_REMOVE, 8'd9, 11'd0);
      send_beat(hbsi_pkg::KIND_FIND, 8'd0, 11'd0);
      end_stream();
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) new_window();
         send_random_item();
      end
      end_stream();
   endtask

   // Back-to-back beats with the receiver always ready.
   task automatic test_unbroken_burst(input int count);
      quiet = 1'b1;
      test_random_mix(count);
      quiet = 1'b0;
   endtask

   // The receiver holds off for a long stretch while finds keep coming.
   task automatic test_held_response();
      hold_start = 1'b1;
      for (int i = 0; i < 60; i++) begin
         if (i % 2 == 0) send_beat(hbsi_pkg::KIND_FIND, pick_size(), pick_slot());
         else send_random_item();
      end
      end_stream();
   endtask

   // Fills many classes, then removes every slot inserted so far, so the index ends empty.
   task automatic test_fill_and_drain();
      slot_ref_type entry;
      repeat (200) begin
         send_beat(hbsi_pkg::KIND_INSERT, SW'($urandom_range(0, NUM_SIZES - 1)),
                   AW'($urandom_range(0, NUM_ADDRS - 1)));
      end
      repeat (20) send_beat(hbsi_pkg::KIND_FIND, SW'($urandom_range(0, NUM_SIZES - 1)), '0);
      while (live_slots.size() > 0) begin
         entry = take_live_slot();
         send_beat(hbsi_pkg::KIND_REMOVE, entry.size_class, entry.slot);
         if ($urandom_range(0, 4) == 0) begin
            send_beat(hbsi_pkg::KIND_FIND, SW'($urandom_range(0, NUM_SIZES - 1)), '0);
         end
      end
      send_beat(hbsi_pkg::KIND_FIND, 8'd0, 11'd0);
      send_beat(hbsi_pkg::KIND_FIND, 8'd255, 11'd0);
      end_stream();
   endtask

   // Response ready: random stalls, a long hold when asked, none in quiet stretches.
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = pick_idle() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Each accepted response beat is compared with the oldest outstanding find.
   always @(posedge clock) begin
      best_fit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_finds.size() == 0) begin
            errors++;
            $display("%0t: unexpected response beat: found %0b size %0d addr %0d",
                     $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[18:8]);
         end else begin
            want = expected_finds.pop_front();
            if (rsp_tuser !== want.found) begin
               errors++;
               $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_tuser);
            end
            if (rsp_tdata[7:0] !== want.best_size) begin
               errors++;
               $display("%0t: best_size expected %0d actual %0d",
                        $time, want.best_size, rsp_tdata[7:0]);
            end
            if (rsp_tdata[18:8] !== want.best_addr) begin
               errors++;
               $display("%0t: best_addr expected %0d actual %0d",
                        $time, want.best_addr, rsp_tdata[18:8]);
            end
         end
      end
   end

   // Guard against a hung handshake.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      class_map = '0;
      for (int s = 0; s < NUM_SIZES; s++) begin
         word_map[s] = '0;
         for (int w = 0; w < LEAF_WORDS; w++) slot_words[s][w] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_index();
      test_extreme_slots();
      test_shared_leaf_word();
      test_random_mix(700);
      test_unbroken_burst(200);
      test_held_response();
      test_random_mix(150);
      test_fill_and_drain();

      // Let every find come back, then allow the block to settle.
      while (expected_finds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
